// ----- sv/rsi_pkg.sv -----
// rsi_pkg: widths, sideband structs and defaults shared by the ray/sphere
// intersection pipeline (top level, square-root pipe and divider pipe).
// No dependencies.
package rsi_pkg;

  // default number of fraction bits of the fixed-point words
  localparam int FRAC_BITS_DEF = 16;

  // quadratic term widths (integer units of 2^-(2*FRAC_BITS))
  localparam int A_W    = 64;   // a = d.d, unsigned
  localparam int H_W    = 66;   // h = d.L, signed
  localparam int HABS_W = 65;   // |h|
  localparam int C_W    = 67;   // c = L.L - r^2, signed
  localparam int CABS_W = 66;   // |c|
  localparam int QABS_W = 67;   // |q| = |h| + s

  // discriminant and its square root
  localparam int HSQ_W  = 131;  // h*h and a*|c|
  localparam int RAD_W  = 132;  // radicand / remainder of the root pipe
  localparam int ROOT_W = 66;   // floor(sqrt(D))

  // limb split of the wide products
  localparam int LIMB_W = 23;
  localparam int NLIMB  = 3;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int ROW_W  = PP_W + 2 * LIMB_W + 1;
  localparam int SUM_W  = ROW_W + 2 * LIMB_W + 1;

  // result distance
  localparam int DIST_W = 31;

  // carried alongside the discriminant through the root pipe
  typedef struct packed {
    logic [A_W-1:0]    a;
    logic [HABS_W-1:0] habs;
    logic              hpos;
    logic [CABS_W-1:0] cabs;
    logic              cneg;
    logic              czero;
    logic              nohit;
    logic              dzero;
  } sq_side_t;

  // carried alongside the two quotients through the divider pipe
  typedef struct packed {
    logic neg0;
    logic neg1;
    logic dzero;
    logic nohit;
  } dv_side_t;

endpackage

// ----- sv/rsi_sqrt.sv -----
// rsi_sqrt: pipelined digit-by-digit integer square root, one root bit per
// stage, with a sideband word carried in step. Depends on rsi_pkg.
module rsi_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [rsi_pkg::RAD_W-1:0] rad,
  input  rsi_pkg::sq_side_t        in_side,
  output logic                     out_vld,
  output logic [rsi_pkg::ROOT_W-1:0] root,
  output rsi_pkg::sq_side_t        out_side
);
  import rsi_pkg::*;

  logic [ROOT_W-1:0] vld;
  logic [RAD_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] res  [ROOT_W];
  sq_side_t          side [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BIT = ROOT_W - 1 - k;
    logic              v_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] res_in;
    sq_side_t          side_in;
    logic [RAD_W-1:0]  trial;
    logic [RAD_W-1:0]  rem_next;
    logic [ROOT_W-1:0] res_next;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = rad;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[k-1];
      assign rem_in  = rem[k-1];
      assign res_in  = res[k-1];
      assign side_in = side[k-1];
    end

    // try setting this root bit: (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b)
    always_comb begin
      trial = (RAD_W'(res_in) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
      if (rem_in >= trial) begin
        rem_next = rem_in - trial;
        res_next = res_in | (ROOT_W'(1) << BIT);
      end else begin
        rem_next = rem_in;
        res_next = res_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= rem_next;
        res[k]  <= res_next;
        side[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld[ROOT_W-1];
  assign root     = res[ROOT_W-1];
  assign out_side = side[ROOT_W-1];

endmodule

// ----- sv/rsi_div.sv -----
// rsi_div: two-lane pipelined restoring divider giving a 31-bit quotient
// that saturates to all ones, one quotient bit per stage. Depends on rsi_pkg.
module rsi_div #(
  parameter int NW = 83,
  parameter int DW = 67
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [NW-1:0]              num0,
  input  logic [NW-1:0]              num1,
  input  logic [DW-1:0]              den0,
  input  logic [DW-1:0]              den1,
  input  rsi_pkg::dv_side_t          in_side,
  output logic                       out_vld,
  output logic [rsi_pkg::DIST_W-1:0] quo0,
  output logic [rsi_pkg::DIST_W-1:0] quo1,
  output rsi_pkg::dv_side_t          out_side
);
  import rsi_pkg::*;

  localparam int QB  = DIST_W;
  localparam int RW  = (NW > DW + QB) ? NW : DW + QB;
  localparam int NST = QB + 1;

  logic [NST-1:0] vld;
  logic [RW-1:0]  rem  [NST][2];
  logic [DW-1:0]  den  [NST][2];
  logic [QB-1:0]  quo  [NST][2];
  logic [1:0]     sat  [NST];
  dv_side_t       side [NST];
  logic [NW-1:0]  num_in [2];
  logic [DW-1:0]  den_in [2];

  assign num_in[0] = num0;
  assign num_in[1] = num1;
  assign den_in[0] = den0;
  assign den_in[1] = den1;

  // first stage: overflow check against den * 2^31
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= RW'(num_in[l]);
        den[0][l] <= den_in[l];
        quo[0][l] <= '0;
        sat[0][l] <= RW'(num_in[l]) >= (RW'(den_in[l]) << QB);
      end
      side[0] <= in_side;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j < NST; j++) begin : g_stage
    localparam int BIT = QB - j;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW-1:0] trial;
      logic          take;
      assign trial = RW'(den[j-1][l]) << BIT;
      assign take  = rem[j-1][l] >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j][l] <= take ? rem[j-1][l] - trial : rem[j-1][l];
          quo[j][l] <= take ? (quo[j-1][l] | (QB'(1) << BIT)) : quo[j-1][l];
          den[j][l] <= den[j-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat[j]  <= sat[j-1];
        side[j] <= side[j-1];
      end
    end
  end

  assign out_vld  = vld[NST-1];
  assign quo0     = sat[NST-1][0] ? '1 : quo[NST-1][0];
  assign quo1     = sat[NST-1][1] ? '1 : quo[NST-1][1];
  assign out_side = side[NST-1];

endmodule

// ----- sv/ray_sphere_intersect_unit.sv -----
// ray_sphere_intersect_unit: top level of the fixed-point ray/sphere test.
// Depends on rsi_pkg, rsi_sqrt and rsi_div.
//
// Takes one ray/sphere word per clock while ray_stall is low and returns one
// hit/distance word per word taken, in order. The pipe is 8 stages that form
// a, h, c and the exact discriminant (wide products split into 23-bit limbs),
// 66 stages of square root (one root bit each), one stage for |q|,
// 32 stages of the two parallel dividers (one quotient bit each) and the
// output register. The whole pipe advances together; a two-entry output
// buffer lets one more word land while a result waits, and ray_stall rises
// only when that buffer is full.
module ray_sphere_intersect_unit #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ray_valid,
  output logic                       ray_stall,
  input  logic signed [31:0]         origin_x,
  input  logic signed [31:0]         origin_y,
  input  logic signed [31:0]         origin_z,
  input  logic signed [31:0]         dir_x,
  input  logic signed [31:0]         dir_y,
  input  logic signed [31:0]         dir_z,
  input  logic signed [31:0]         center_x,
  input  logic signed [31:0]         center_y,
  input  logic signed [31:0]         center_z,
  input  logic [30:0]                radius_sq,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       hit,
  output logic [rsi_pkg::DIST_W-1:0] distance
);
  import rsi_pkg::*;

  localparam int NUM_W = QABS_W + FRAC_BITS;

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8, vg;
  logic skid_v, v_o;

  // stage 1: L = origin - centre
  logic signed [32:0] l1 [3];
  logic signed [31:0] d1 [3];
  logic [30:0]        rsq1;

  // stage 2: component products
  logic [62:0]        dd2 [3];
  logic signed [64:0] dl2 [3];
  logic [64:0]        ll2 [3];
  logic [30:0]        rsq2;

  // stage 3: a, h, c
  logic [A_W-1:0]        a3;
  logic signed [H_W-1:0] h3;
  logic signed [C_W-1:0] c3;

  // stages 4..8
  sq_side_t          s4, s5, s6, s7, s8;
  logic [PP_W-1:0]   pph5 [NLIMB][NLIMB];
  logic [PP_W-1:0]   ppa5 [NLIMB][NLIMB];
  logic [ROW_W-1:0]  rowh6 [NLIMB];
  logic [ROW_W-1:0]  rowa6 [NLIMB];
  logic [HSQ_W-1:0]  hsq7, acm7;
  logic [RAD_W-1:0]  rad8;

  assign adv       = !skid_v;
  assign ray_stall = skid_v;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (adv) begin
      v1 <= ray_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      l1[0] <= {origin_x[31], origin_x} - {center_x[31], center_x};
      l1[1] <= {origin_y[31], origin_y} - {center_y[31], center_y};
      l1[2] <= {origin_z[31], origin_z} - {center_z[31], center_z};
      d1[0] <= dir_x;
      d1[1] <= dir_y;
      d1[2] <= dir_z;
      rsq1  <= radius_sq;
    end
  end

  // stage 2
  logic signed [63:0] pdd [3];
  logic signed [64:0] pdl [3];
  logic signed [65:0] pll [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdd[i] = d1[i] * d1[i];
      pdl[i] = d1[i] * l1[i];
      pll[i] = l1[i] * l1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd2[i] <= pdd[i][62:0];
        dl2[i] <= pdl[i];
        ll2[i] <= pll[i][64:0];
      end
      rsq2 <= rsq1;
    end
  end

  // stage 3: sums
  logic [C_W-1:0] ll_sum;
  assign ll_sum = C_W'(ll2[0]) + C_W'(ll2[1]) + C_W'(ll2[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= A_W'(dd2[0]) + A_W'(dd2[1]) + A_W'(dd2[2]);
      h3 <= {dl2[0][64], dl2[0]} + {dl2[1][64], dl2[1]} + {dl2[2][64], dl2[2]};
      c3 <= ll_sum - (C_W'(rsq2) << FRAC_BITS);
    end
  end

  // stage 4: magnitudes and flags
  logic [H_W-1:0] h_neg;
  logic [C_W-1:0] c_neg;
  assign h_neg = -h3;
  assign c_neg = -c3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4.a     <= a3;
      s4.habs  <= h3[H_W-1] ? h_neg[HABS_W-1:0] : h3[HABS_W-1:0];
      s4.hpos  <= !h3[H_W-1] && (h3 != '0);
      s4.cabs  <= c3[C_W-1] ? c_neg[CABS_W-1:0] : c3[CABS_W-1:0];
      s4.cneg  <= c3[C_W-1];
      s4.czero <= (c3 == '0);
      s4.nohit <= (a3 == '0);
      s4.dzero <= 1'b0;
    end
  end

  // stage 5: limb partial products of h*h and a*|c|
  logic [NLIMB*LIMB_W-1:0] hl, al, cl;
  assign hl = (NLIMB*LIMB_W)'(s4.habs);
  assign al = (NLIMB*LIMB_W)'(s4.a);
  assign cl = (NLIMB*LIMB_W)'(s4.cabs);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NLIMB; i++) begin
        for (int j = 0; j < NLIMB; j++) begin
          pph5[i][j] <= hl[LIMB_W*i +: LIMB_W] * hl[LIMB_W*j +: LIMB_W];
          ppa5[i][j] <= al[LIMB_W*i +: LIMB_W] * cl[LIMB_W*j +: LIMB_W];
        end
      end
      s5 <= s4;
    end
  end

  // stage 6: row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NLIMB; i++) begin
        rowh6[i] <= ROW_W'(pph5[i][0]) + (ROW_W'(pph5[i][1]) << LIMB_W)
                  + (ROW_W'(pph5[i][2]) << (2 * LIMB_W));
        rowa6[i] <= ROW_W'(ppa5[i][0]) + (ROW_W'(ppa5[i][1]) << LIMB_W)
                  + (ROW_W'(ppa5[i][2]) << (2 * LIMB_W));
      end
      s6 <= s5;
    end
  end

  // stage 7: full products
  logic [SUM_W-1:0] sum_h, sum_a;
  assign sum_h = SUM_W'(rowh6[0]) + (SUM_W'(rowh6[1]) << LIMB_W)
               + (SUM_W'(rowh6[2]) << (2 * LIMB_W));
  assign sum_a = SUM_W'(rowa6[0]) + (SUM_W'(rowa6[1]) << LIMB_W)
               + (SUM_W'(rowa6[2]) << (2 * LIMB_W));

  always_ff @(posedge clk) begin
    if (adv) begin
      hsq7 <= sum_h[HSQ_W-1:0];
      acm7 <= sum_a[HSQ_W-1:0];
      s7   <= s6;
    end
  end

  // stage 8: discriminant D = h*h - a*c, sign and zero flags
  sq_side_t s8_next;

  always_comb begin
    s8_next       = s7;
    s8_next.nohit = s7.nohit || (!s7.cneg && (hsq7 < acm7));
    s8_next.dzero = !s7.cneg && (hsq7 == acm7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad8 <= s7.cneg ? RAD_W'(hsq7) + RAD_W'(acm7) : RAD_W'(hsq7) - RAD_W'(acm7);
      s8   <= s8_next;
    end
  end

  // square root of D
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (v8),
    .rad      (rad8),
    .in_side  (s8),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // |q| = |h| + s; q is negative exactly when h > 0
  logic [QABS_W-1:0] qabs;
  logic [NUM_W-1:0]  numg0, numg1;
  logic [QABS_W-1:0] deng0, deng1;
  dv_side_t          dsg;

  assign qabs = QABS_W'(sq_side.habs) + QABS_W'(sq_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numg0     <= NUM_W'(qabs) << FRAC_BITS;
      deng0     <= QABS_W'(sq_side.a);
      numg1     <= NUM_W'(sq_side.cabs) << FRAC_BITS;
      deng1     <= qabs;
      dsg.neg0  <= sq_side.hpos;
      dsg.neg1  <= sq_side.cneg ? !sq_side.hpos : (sq_side.hpos && !sq_side.czero);
      dsg.dzero <= sq_side.dzero;
      dsg.nohit <= sq_side.nohit;
    end
  end

  // x0 = q/a and x1 = c/q
  logic              dv_vld;
  logic [DIST_W-1:0] t0, t1;
  dv_side_t          dv_side;

  rsi_div #(
    .NW (NUM_W),
    .DW (QABS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vg),
    .num0     (numg0),
    .num1     (numg1),
    .den0     (deng0),
    .den1     (deng1),
    .in_side  (dsg),
    .out_vld  (dv_vld),
    .quo0     (t0),
    .quo1     (t1),
    .out_side (dv_side)
  );

  // pick the nearer root that is not behind the origin
  logic              n0, n1, hit_n;
  logic [DIST_W-1:0] x1, dist_n;

  always_comb begin
    n0    = dv_side.neg0;
    n1    = dv_side.dzero ? dv_side.neg0 : dv_side.neg1;
    x1    = dv_side.dzero ? t0 : t1;
    hit_n = !dv_side.nohit && !(n0 && n1);
    priority if (!hit_n) begin
      dist_n = '0;
    end else if (n0) begin
      dist_n = x1;
    end else if (n1) begin
      dist_n = t0;
    end else begin
      dist_n = (t0 < x1) ? t0 : x1;
    end
  end

  // output register with one skid entry
  logic              take;
  logic              skid_hit;
  logic [DIST_W-1:0] skid_dist;

  assign take = v_o && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o    <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      priority if (skid_v) begin
        if (take) begin
          skid_v <= 1'b0;
        end
      end else if (dv_vld) begin
        if (!v_o || take) begin
          v_o <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else begin
        if (take) begin
          v_o <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_v) begin
      if (take) begin
        hit      <= skid_hit;
        distance <= skid_dist;
      end
    end else if (dv_vld) begin
      if (!v_o || take) begin
        hit      <= hit_n;
        distance <= dist_n;
      end else begin
        skid_hit  <= hit_n;
        skid_dist <= dist_n;
      end
    end else begin
      // no new word, hold
    end
  end

  assign result_valid = v_o;

  // the skid entry is only ever used behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> v_o)
    else $error("skid entry full while output register empty");

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !hit) |-> (distance == '0))
    else $error("miss with nonzero distance");

  // a parked word stays parked while the output is stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_v && result_stall) |=> skid_v)
    else $error("skid word lost under stall");

  // the front stage keeps its word while the pipe is frozen
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (!adv && v8) |=> v8)
    else $error("front stage lost a word while frozen");

endmodule
